// ===== rtl/affra_pkg.sv =====
`timescale 1ns / 1ps
package affra_pkg;
    localparam int ADDR_BITS = 48;
    localparam int SIZE_W    = ADDR_BITS + 1;
    localparam int OFS_W     = ADDR_BITS;
    localparam int ALOG_W    = 6;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        OP_RESERVE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef struct packed {
        logic             op;
        logic [SIZE_W-1:0] size;
        logic [ALOG_W-1:0] alog;
        logic [OFS_W-1:0]  ofs;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFS_W-1:0] offset;
    } rsp_t;
endpackage

// ===== rtl/aligned_first_fit_range_allocator_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tuser: op; tdata: req_size, align_log2, block_offset
// m_axis    out        tdata: status, granted_offset
// cfg       in         total_size
// An item goes through acceptance, a scan of the blocks, a decision, any shifting of
// table entries, write-back and the response. The table's read data is registered, so
// each scanned block takes a read state and a scan state, and each shifted entry a read
// and a write state. Reset is synchronous and clears the block count; table entries are
// written before they are read. Items are taken one at a time; the result is held
// until m_axis_tready.
module aligned_first_fit_range_allocator_top #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [48:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata, // req_size, align_log2, block_offset
    input  logic [0:0]   s_axis_tuser, // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata  // status, granted_offset
);
    import affra_pkg::*;

    req_t req;
    rsp_t rsp;

    assign req.op   = s_axis_tuser[0];
    assign req.size = s_axis_tdata[48:0];
    assign req.alog = s_axis_tdata[54:49];
    assign req.ofs  = s_axis_tdata[102:55];
    assign m_axis_tdata = {6'b0, rsp.offset, rsp.status};

    affra_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .req_valid(s_axis_tvalid), .req_ready(s_axis_tready), .req(req),
        .rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp(rsp)
    );
endmodule

// ===== rtl/affra_table.sv =====
`timescale 1ns / 1ps
module affra_table #(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6,
    parameter int DATA_W = 97
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/affra_ctrl.sv =====
`timescale 1ns / 1ps
module affra_ctrl #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [48:0]          cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  affra_pkg::req_t      req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output affra_pkg::rsp_t      rsp
);
    import affra_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W = OFS_W + SIZE_W;
    localparam logic [SIZE_W-1:0] LIMIT = SIZE_W'(1) << ADDR_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_SCAN, S_DECIDE, S_SHUP_RD, S_SHUP_WR, S_SHDN_RD, S_SHDN_WR,
        S_FIN1, S_FIN2, S_RESP
    } state_t;

    typedef enum logic [1:0] {
        K_NONE, K_SHUP, K_SHDN
    } kind_t;

    state_t            state_reg;
    req_t              req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] total_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic [SIZE_W:0]   ps_reg, pe_reg;
    logic              have_prev_reg;
    logic [SIZE_W:0]   a_reg, e_reg, s_reg;
    logic [1:0]        status_reg;
    logic [OFS_W-1:0]  got_reg;
    logic              rsp_valid_reg;
    kind_t             kind_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [ENT_W-1:0]  wr_data, rd_data;
    logic [ENT_W-1:0]  hold_reg;
    logic [ENT_W-1:0]  fin2_reg;
    logic              fin2_en_reg;
    logic [IDX_W-1:0]  fin2_addr_reg;

    logic [SIZE_W:0]   cs, ce, ca, mask, rsz, rofs, rend;
    logic [ALOG_W-1:0] alog_c;
    logic [OFS_W-1:0]  rd_start;
    logic [SIZE_W-1:0] rd_len;
    logic [SIZE_W-1:0] cfg_clamped;

    assign rd_start = rd_data[ENT_W-1:SIZE_W];
    assign rd_len   = rd_data[SIZE_W-1:0];
    assign cs   = {2'b0, rd_start};
    assign ce   = cs + {1'b0, rd_len};
    assign alog_c = (req_reg.alog > ALOG_W'(SIZE_W)) ? ALOG_W'(SIZE_W) : req_reg.alog;
    assign mask = ({{SIZE_W{1'b0}}, 1'b1} << alog_c) - 1'b1;
    assign ca   = (cs + mask) & ~mask;
    assign rsz  = {1'b0, req_reg.size};
    assign rofs = {2'b0, req_reg.ofs};
    assign rend = rofs + rsz;
    assign cfg_clamped = (cfg_data > LIMIT) ? LIMIT : cfg_data;

    assign cfg_ready = aresetn && (state_reg == S_IDLE);
    assign req_ready = aresetn && (state_reg == S_IDLE) && !cfg_valid;
    assign rsp_valid = rsp_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.offset = got_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_addr = idx_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                wr_en   = cfg_valid && cfg_ready && (cfg_clamped != '0);
                wr_data = {{OFS_W{1'b0}}, cfg_clamped};
                rd_addr = '0;
            end
            S_SHUP_RD: rd_addr = IDX_W'(ptr_reg - 1'b1);
            S_SHUP_WR: begin
                wr_en = 1'b1; wr_addr = ptr_reg[IDX_W-1:0]; wr_data = rd_data;
            end
            S_SHDN_RD: rd_addr = IDX_W'(ptr_reg + 1'b1);
            S_SHDN_WR: begin
                wr_en = 1'b1; wr_addr = ptr_reg[IDX_W-1:0]; wr_data = rd_data;
            end
            S_FIN1: begin
                wr_en = 1'b1; wr_addr = idx_reg[IDX_W-1:0]; wr_data = hold_reg;
            end
            S_FIN2: begin
                wr_en = fin2_en_reg; wr_addr = fin2_addr_reg; wr_data = fin2_reg;
            end
            default: ;
        endcase
    end

    affra_table #(.DEPTH(MAX_BLOCKS), .IDX_W(IDX_W), .DATA_W(ENT_W)) u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    function automatic logic [ENT_W-1:0] ent(input logic [SIZE_W:0] st,
                                             input logic [SIZE_W:0] ln);
        return {st[OFS_W-1:0], ln[SIZE_W-1:0]};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cfg_valid) begin
                        total_reg <= cfg_clamped;
                        count_reg <= (cfg_clamped == '0) ? '0 : CNT_W'(1);
                    end else if (req_valid) begin
                        req_reg       <= req;
                        idx_reg       <= '0;
                        have_prev_reg <= 1'b0;
                        got_reg       <= '0;
                        fin2_en_reg   <= 1'b0;
                        kind_reg      <= K_NONE;
                        if (req.size == '0) begin
                            status_reg <= ST_BAD; state_reg <= S_RESP;
                        end else if (req.op == OP_RELEASE &&
                                     ({2'b0, req.ofs} + {1'b0, req.size}) >
                                     {1'b0, total_reg}) begin
                            status_reg <= ST_BAD; state_reg <= S_RESP;
                        end else begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (idx_reg == count_reg) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (req_reg.op == OP_RESERVE) begin
                        if (ca < ce && (ce - ca) >= rsz) begin
                            a_reg <= ca; e_reg <= ce; s_reg <= cs;
                            state_reg <= S_DECIDE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= (idx_reg + 1'b1 == count_reg) ? S_DECIDE : S_RD;
                        end
                    end else begin
                        if (cs < rofs) begin
                            ps_reg <= cs; pe_reg <= ce; have_prev_reg <= 1'b1;
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= (idx_reg + 1'b1 == count_reg) ? S_DECIDE : S_RD;
                        end else begin
                            s_reg <= cs; e_reg <= ce;
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    state_reg  <= S_RESP;
                    status_reg <= ST_OK;
                    if (req_reg.op == OP_RESERVE) begin
                        if (idx_reg == count_reg) begin
                            status_reg <= ST_NOFIT;
                        end else begin
                            got_reg <= a_reg[OFS_W-1:0];
                            if (a_reg != s_reg && e_reg != a_reg + rsz) begin
                                if (count_reg >= CNT_W'(MAX_BLOCKS)) begin
                                    status_reg <= ST_FULL; got_reg <= '0;
                                end else begin
                                    hold_reg      <= ent(s_reg, a_reg - s_reg);
                                    fin2_en_reg   <= 1'b1;
                                    fin2_addr_reg <= IDX_W'(idx_reg + 1'b1);
                                    fin2_reg      <= ent(a_reg + rsz, e_reg - a_reg - rsz);
                                    ptr_reg       <= count_reg;
                                    count_reg     <= count_reg + 1'b1;
                                    idx_reg       <= idx_reg;
                                    kind_reg      <= K_SHUP;
                                    // shift entries above idx up by one
                                    state_reg <= (count_reg == idx_reg + 1'b1) ?
                                                 S_FIN1 : S_SHUP_RD;
                                end
                            end else if (a_reg != s_reg) begin
                                hold_reg <= ent(s_reg, a_reg - s_reg); state_reg <= S_FIN1;
                            end else if (e_reg != a_reg + rsz) begin
                                hold_reg <= ent(a_reg + rsz, e_reg - a_reg - rsz);
                                state_reg <= S_FIN1;
                            end else begin
                                ptr_reg   <= idx_reg;
                                count_reg <= count_reg - 1'b1;
                                state_reg <= (idx_reg + 1'b1 == count_reg) ? S_RESP : S_SHDN_RD;
                            end
                        end
                    end else begin
                        logic jp, jn, nx;
                        jp = 1'b0; jn = 1'b0;
                        nx = (idx_reg != count_reg);
                        if (have_prev_reg && ps_reg <= rofs && pe_reg >= rend) begin
                            state_reg <= S_RESP;
                        end else if (have_prev_reg && pe_reg > rofs) begin
                            status_reg <= ST_BAD;
                        end else if (nx && s_reg < rend) begin
                            if (!(s_reg <= rofs && e_reg >= rend)) status_reg <= ST_BAD;
                        end else begin
                            jp = have_prev_reg && (pe_reg == rofs);
                            jn = nx && (s_reg == rend);
                            if (jp && jn) begin
                                hold_reg  <= ent(ps_reg, e_reg - ps_reg);
                                idx_reg   <= idx_reg - 1'b1;
                                ptr_reg   <= idx_reg;
                                count_reg <= count_reg - 1'b1;
                                kind_reg  <= K_SHDN;
                                state_reg <= S_FIN1;
                            end else if (jp) begin
                                hold_reg  <= ent(ps_reg, rend - ps_reg);
                                idx_reg   <= idx_reg - 1'b1;
                                state_reg <= S_FIN1;
                            end else if (jn) begin
                                hold_reg  <= ent(rofs, e_reg - rofs);
                                state_reg <= S_FIN1;
                            end else if (count_reg >= CNT_W'(MAX_BLOCKS)) begin
                                status_reg <= ST_FULL;
                            end else begin
                                hold_reg  <= ent(rofs, rsz);
                                ptr_reg   <= count_reg;
                                count_reg <= count_reg + 1'b1;
                                kind_reg  <= K_SHUP;
                                state_reg <= (count_reg == idx_reg) ? S_FIN1 : S_SHUP_RD;
                            end
                        end
                    end
                end
                S_SHUP_RD: state_reg <= S_SHUP_WR;
                S_SHUP_WR: begin
                    ptr_reg <= ptr_reg - 1'b1;
                    if (req_reg.op == OP_RESERVE) begin
                        state_reg <= (ptr_reg - 1'b1 == idx_reg + 1'b1) ? S_FIN1 : S_SHUP_RD;
                    end else begin
                        state_reg <= (ptr_reg - 1'b1 == idx_reg) ? S_FIN1 : S_SHUP_RD;
                    end
                end
                S_SHDN_RD: state_reg <= S_SHDN_WR;
                S_SHDN_WR: begin
                    ptr_reg <= ptr_reg + 1'b1;
                    state_reg <= (ptr_reg + 1'b1 == count_reg) ? S_RESP : S_SHDN_RD;
                end
                S_FIN1: begin
                    if (fin2_en_reg) begin
                        state_reg <= S_FIN2;
                    end else if (kind_reg == K_SHDN && ptr_reg != count_reg) begin
                        state_reg <= S_SHDN_RD;
                    end else begin
                        state_reg <= S_RESP;
                    end
                end
                S_FIN2: state_reg <= S_RESP;
                S_RESP: begin
                    if (!rsp_valid_reg) begin
                        rsp_valid_reg <= 1'b1;
                    end else if (rsp_ready) begin
                        rsp_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (count_reg <= CNT_W'(MAX_BLOCKS))
                else $error("block count above capacity");
        end
    end

    property p_rsp_holds;
        @(posedge aclk) disable iff (!aresetn)
            rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp.status);
    endproperty
    a_rsp_holds: assert property (p_rsp_holds) else $error("response changed while stalled");

    property p_no_write_resp;
        @(posedge aclk) disable iff (!aresetn) rsp_valid |-> !wr_en;
    endproperty
    a_no_write_resp: assert property (p_no_write_resp) else $error("table write during response");

    property p_grant_ok;
        @(posedge aclk) disable iff (!aresetn)
            rsp_valid && rsp.status != ST_OK |-> rsp.offset == '0;
    endproperty
    a_grant_ok: assert property (p_grant_ok) else $error("offset on failed request");
endmodule
